// ----- rtl/clrc_pkg.sv -----
// Shared types, codes and constants of the character LCD request controller.
package clrc_pkg;

	localparam int DEF_SLOTS      = 4;
	localparam int DEF_MAX_STRING = 32;
	localparam int DEF_COLUMNS    = 16;

	localparam int CFG_W     = 8;
	localparam int CFG_IDX_W = 3;

	localparam logic [7:0] LCD_CLEAR       = 8'h01;
	localparam logic [7:0] LINE0_BASE      = 8'h80;
	localparam logic [7:0] LINE1_BASE      = 8'hC0;
	localparam logic [7:0] FSET_BASE       = 8'h30;
	localparam logic [7:0] DCTRL_BASE      = 8'h08;
	localparam logic [7:0] POWER_UP_RESET  = 8'd19;
	localparam logic [7:0] WAIT_MAX        = 8'hFF;

	typedef enum logic [2:0] {
		CMD_TICK     = 3'd0,
		CMD_STRING   = 3'd1,
		CMD_CLEAR    = 3'd2,
		CMD_RAW      = 3'd3,
		CMD_POSITION = 3'd4
	} cmd_code_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_NO_SLOT  = 2'd1,
		ST_BAD_POS  = 2'd2,
		ST_TOO_LONG = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		IP_POWER = 3'd0,
		IP_FSET  = 3'd1,
		IP_DCTRL = 3'd2,
		IP_CLEAR = 3'd3,
		IP_END   = 3'd4,
		IP_RUN   = 3'd5
	} init_phase_t;

	typedef enum logic [2:0] {
		KIND_NONE  = 3'd0,
		KIND_WRITE = 3'd1,
		KIND_CLEAR = 3'd2,
		KIND_CMD   = 3'd3,
		KIND_POS   = 3'd4,
		KIND_DONE  = 3'd5
	} kind_t;

	typedef enum logic [1:0] {
		SPH_START = 2'd0,
		SPH_BUSY  = 2'd1,
		SPH_DONE  = 2'd2
	} slot_phase_t;

	typedef enum logic [2:0] {
		CFG_DISPLAY_ON     = 3'd0,
		CFG_CURSOR_ON      = 3'd1,
		CFG_BLINK_ON       = 3'd2,
		CFG_TWO_LINES      = 3'd3,
		CFG_LARGE_FONT     = 3'd4,
		CFG_POWER_UP_TICKS = 3'd5
	} cfg_reg_t;

	typedef enum logic {
		CTL_IDLE = 1'b0,
		CTL_EXEC = 1'b1
	} ctl_state_t;

	typedef struct packed {
		logic [2:0] command;
		logic [7:0] data_byte;
		logic       last_char;
		logic [1:0] row;
		logic [4:0] column;
	} req_t;

	typedef struct packed {
		logic [1:0] status;
		logic       lcd_rs;
		logic       lcd_enable;
		logic [7:0] lcd_data;
		logic       operational;
	} rsp_t;

	typedef struct packed {
		logic capture;
		logic execute;
	} ctl_cmd_t;

endpackage

// ----- rtl/char_lcd_request_controller.sv -----
// Top level of the character LCD request controller.
// The req channel carries one item per handshake: a tick, a string character, a clear,
// a raw command or a cursor position. Each accepted item yields exactly one result item
// on the rsp channel: the request status and the LCD pin levels after that item.
// Ticks pace the power-up wait, the init commands and the enable strobes; requests are
// queued in the lowest free slot and served lowest slot first.
// An item is taken when req_valid is high and req_stall is low; a result is taken when
// rsp_valid is high and rsp_stall is low.
// Each item is captured while the character store is read, and is then executed to
// update the state. The result valid register is set by that execute step, and the
// next item is taken only after it, back in the idle state, so no item is taken while
// the last one is executing; execution uses the registered read data of the store.
// While the receiver stalls, the result holds and a new item is taken only in the cycle
// the waiting result leaves.
// Reset clears the slots, the sequencer and the pin levels and loads the register
// defaults; no clearing pass is needed. Configuration writes are taken at any edge.
module char_lcd_request_controller import clrc_pkg::*; #(
	parameter int SLOTS      = DEF_SLOTS,
	parameter int MAX_STRING = DEF_MAX_STRING,
	parameter int COLUMNS    = DEF_COLUMNS
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 req_valid,
	output logic                 req_stall,
	input  req_t                 req,
	output logic                 rsp_valid,
	input  logic                 rsp_stall,
	output rsp_t                 rsp,
	input  logic                 cfg_write,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data
);

	ctl_cmd_t cmd;

	clrc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.cmd       (cmd)
	);

	clrc_dp #(
		.SLOTS      (SLOTS),
		.MAX_STRING (MAX_STRING),
		.COLUMNS    (COLUMNS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.req       (req),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.rsp       (rsp)
	);

endmodule

// ----- rtl/clrc_ctrl.sv -----
// Controller state machine: item handshake, execute sequencing and result valid.
module clrc_ctrl import clrc_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     req_valid,
	output logic     req_stall,
	output logic     rsp_valid,
	input  logic     rsp_stall,
	output ctl_cmd_t cmd
);

	ctl_state_t state_q, state_n;
	logic       rsp_valid_q;
	logic       take_ok;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= CTL_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			if (state_q == CTL_EXEC) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		take_ok     = (state_q == CTL_IDLE) && (!rsp_valid_q || !rsp_stall);
		cmd.capture = take_ok && req_valid;
		cmd.execute = (state_q == CTL_EXEC);
		state_n     = state_q;
		case (state_q)
			CTL_IDLE: begin
				if (cmd.capture) begin
					state_n = CTL_EXEC;
				end
			end
			CTL_EXEC: begin
				state_n = CTL_IDLE;
			end
			default: begin
				state_n = CTL_IDLE;
			end
		endcase
	end

	assign req_stall = !take_ok;
	assign rsp_valid = rsp_valid_q;

endmodule

// ----- rtl/clrc_dp.sv -----
// Datapath: configuration, power-up sequencer, request slots, character store and pins.
module clrc_dp import clrc_pkg::*; #(
	parameter int SLOTS      = DEF_SLOTS,
	parameter int MAX_STRING = DEF_MAX_STRING,
	parameter int COLUMNS    = DEF_COLUMNS
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  ctl_cmd_t             cmd,
	input  req_t                 req,
	input  logic                 cfg_write,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	output rsp_t                 rsp
);

	localparam int SLOT_W    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int LEN_W     = $clog2(MAX_STRING + 1);
	localparam int MEM_DEPTH = SLOTS * MAX_STRING;
	localparam int ADDR_W    = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
	localparam logic [5:0]       COL_LIMIT = 6'(COLUMNS);
	localparam logic [LEN_W-1:0] LEN_LIMIT = LEN_W'(MAX_STRING);

	req_t              item_s1;

	logic              display_on_q, cursor_on_q, blink_on_q, two_lines_q, large_font_q;
	logic [7:0]        power_up_q;

	init_phase_t       ip_q;
	logic [7:0]        wait_q;
	logic              en_q;
	logic              rs_q;
	logic [7:0]        data_q;
	status_t           status_q;
	logic [SLOT_W-1:0] serving_q;
	logic [SLOTS-1:0]  occ_q;
	kind_t             kind_q   [SLOTS];
	slot_phase_t       phase_q  [SLOTS];
	logic [5:0]        pos_q    [SLOTS];
	logic [LEN_W-1:0]  len_q    [SLOTS];
	logic [LEN_W-1:0]  cursor_q [SLOTS];
	logic [7:0]        cmdb_q   [SLOTS];
	logic              open_q;
	logic [SLOT_W-1:0] open_slot_q;
	logic [LEN_W-1:0]  open_len_q;

	logic [7:0]        chars_mem [MEM_DEPTH];
	logic [7:0]        rd_data_q;

	kind_t             kind_s;
	slot_phase_t       phase_s;
	logic [5:0]        pos_s;
	logic [LEN_W-1:0]  len_s;
	logic [LEN_W-1:0]  cursor_s;
	logic [7:0]        cmdb_s;
	logic              free_found, next_found;
	logic [SLOT_W-1:0] free_idx, next_idx;
	logic [7:0]        svc_byte, fs_byte, dc_byte;
	logic              stb_req, stb_rs, stb_release;
	logic [7:0]        stb_byte;
	logic              is_tick, is_string, pos_ok, is_enq;
	kind_t             enq_kind;
	logic [SLOT_W-1:0] str_slot;
	logic              str_go, str_room;
	logic [LEN_W-1:0]  str_len, str_len_n;
	logic              enq_we, close_we, cur_inc, mem_we;
	logic [ADDR_W-1:0] wr_addr, rd_addr;

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			item_s1 <= req;
		end
	end

	always_comb begin
		kind_s   = kind_q[serving_q];
		phase_s  = phase_q[serving_q];
		pos_s    = pos_q[serving_q];
		len_s    = len_q[serving_q];
		cursor_s = cursor_q[serving_q];
		cmdb_s   = cmdb_q[serving_q];

		free_found = 1'b0;
		free_idx   = '0;
		next_found = 1'b0;
		next_idx   = '0;
		for (int i = SLOTS - 1; i >= 0; i--) begin
			if (!occ_q[i]) begin
				free_found = 1'b1;
				free_idx   = SLOT_W'(i);
			end
			if (occ_q[i] && (SLOT_W'(i) != serving_q)) begin
				next_found = 1'b1;
				next_idx   = SLOT_W'(i);
			end
		end

		fs_byte = FSET_BASE | {4'b0000, two_lines_q, large_font_q, 2'b00};
		dc_byte = DCTRL_BASE | {5'b00000, display_on_q, cursor_on_q, blink_on_q};

		case (kind_s)
			KIND_CLEAR: svc_byte = LCD_CLEAR;
			KIND_CMD:   svc_byte = cmdb_s;
			default:    svc_byte = (pos_s[5] ? LINE1_BASE : LINE0_BASE) + {3'b000, pos_s[4:0]};
		endcase

		is_tick   = (item_s1.command == CMD_TICK);
		is_string = (item_s1.command == CMD_STRING);

		stb_req  = 1'b0;
		stb_rs   = 1'b0;
		stb_byte = 8'h00;
		if (is_tick) begin
			case (ip_q)
				IP_FSET: begin
					if (wait_q >= power_up_q) begin
						stb_req  = 1'b1;
						stb_byte = fs_byte;
					end
				end
				IP_DCTRL: begin
					stb_req  = 1'b1;
					stb_byte = dc_byte;
				end
				IP_CLEAR: begin
					stb_req  = 1'b1;
					stb_byte = LCD_CLEAR;
				end
				IP_RUN: begin
					case (kind_s)
						KIND_WRITE: begin
							if (phase_s == SPH_BUSY && cursor_s < len_s) begin
								stb_req  = 1'b1;
								stb_rs   = 1'b1;
								stb_byte = rd_data_q;
							end
						end
						KIND_CLEAR, KIND_CMD, KIND_POS: begin
							if (phase_s == SPH_BUSY) begin
								stb_req  = 1'b1;
								stb_byte = svc_byte;
							end
						end
						default: begin
						end
					endcase
				end
				default: begin
				end
			endcase
		end
		stb_release = stb_req && en_q;

		pos_ok = (item_s1.row[1] == 1'b0) && ({1'b0, item_s1.column} < COL_LIMIT);
		case (item_s1.command)
			CMD_CLEAR: begin
				is_enq   = 1'b1;
				enq_kind = KIND_CLEAR;
			end
			CMD_RAW: begin
				is_enq   = 1'b1;
				enq_kind = KIND_CMD;
			end
			CMD_POSITION: begin
				is_enq   = pos_ok;
				enq_kind = KIND_POS;
			end
			default: begin
				is_enq   = 1'b0;
				enq_kind = KIND_NONE;
			end
		endcase

		str_slot  = open_q ? open_slot_q : free_idx;
		str_go    = open_q || free_found;
		str_len   = open_q ? open_len_q : '0;
		str_room  = (str_len < LEN_LIMIT);
		str_len_n = str_room ? str_len + LEN_W'(1) : str_len;

		enq_we   = cmd.execute && is_enq && free_found;
		close_we = cmd.execute && is_string && str_go && item_s1.last_char;
		cur_inc  = cmd.execute && is_tick && (ip_q == IP_RUN) && (kind_s == KIND_WRITE)
			&& stb_release;
		mem_we   = cmd.execute && is_string && str_go && str_room;
		wr_addr  = ADDR_W'(str_slot * MAX_STRING) + ADDR_W'(str_len);
		rd_addr  = ADDR_W'(serving_q * MAX_STRING) + ADDR_W'(cursor_s);
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			chars_mem[wr_addr] <= item_s1.data_byte;
		end
		rd_data_q <= chars_mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (enq_we) begin
			cmdb_q[free_idx] <= item_s1.data_byte;
			pos_q[free_idx]  <= {item_s1.row[0], item_s1.column};
		end
		if (close_we) begin
			len_q[str_slot]    <= str_len_n;
			cursor_q[str_slot] <= '0;
		end
		if (cur_inc) begin
			cursor_q[serving_q] <= cursor_s + LEN_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			display_on_q <= 1'b1;
			cursor_on_q  <= 1'b0;
			blink_on_q   <= 1'b0;
			two_lines_q  <= 1'b1;
			large_font_q <= 1'b0;
			power_up_q   <= POWER_UP_RESET;
			ip_q         <= IP_POWER;
			wait_q       <= 8'h00;
			en_q         <= 1'b0;
			rs_q         <= 1'b0;
			data_q       <= 8'h00;
			status_q     <= ST_OK;
			serving_q    <= '0;
			occ_q        <= '0;
			for (int i = 0; i < SLOTS; i++) begin
				kind_q[i]  <= KIND_NONE;
				phase_q[i] <= SPH_START;
			end
			open_q      <= 1'b0;
			open_slot_q <= '0;
			open_len_q  <= '0;
		end else begin
			if (cfg_write) begin
				case (cfg_index)
					CFG_DISPLAY_ON:     display_on_q <= cfg_data[0];
					CFG_CURSOR_ON:      cursor_on_q  <= cfg_data[0];
					CFG_BLINK_ON:       blink_on_q   <= cfg_data[0];
					CFG_TWO_LINES:      two_lines_q  <= cfg_data[0];
					CFG_LARGE_FONT:     large_font_q <= cfg_data[0];
					CFG_POWER_UP_TICKS: power_up_q   <= cfg_data[7:0];
					default: begin
					end
				endcase
			end
			if (cmd.execute) begin
				status_q <= ST_OK;
				if (stb_req) begin
					if (!en_q) begin
						rs_q   <= stb_rs;
						data_q <= stb_byte;
						en_q   <= 1'b1;
					end else begin
						en_q <= 1'b0;
					end
				end
				case (item_s1.command)
					CMD_TICK: begin
						case (ip_q)
							IP_POWER: begin
								en_q <= 1'b0;
								ip_q <= IP_FSET;
							end
							IP_FSET: begin
								if (stb_release) begin
									ip_q <= IP_DCTRL;
								end
								if (wait_q != WAIT_MAX) begin
									wait_q <= wait_q + 8'd1;
								end
							end
							IP_DCTRL: begin
								if (stb_release) begin
									ip_q <= IP_CLEAR;
								end
							end
							IP_CLEAR: begin
								if (stb_release) begin
									ip_q <= IP_END;
								end
							end
							IP_END: begin
								ip_q <= IP_RUN;
							end
							IP_RUN: begin
								case (kind_s)
									KIND_WRITE: begin
										if (phase_s == SPH_START) begin
											phase_q[serving_q] <= SPH_BUSY;
										end else if (phase_s == SPH_BUSY && !(cursor_s < len_s)) begin
											kind_q[serving_q] <= KIND_DONE;
										end
									end
									KIND_CLEAR, KIND_CMD, KIND_POS: begin
										if (phase_s == SPH_START) begin
											phase_q[serving_q] <= SPH_BUSY;
										end else if (phase_s == SPH_BUSY && stb_release) begin
											kind_q[serving_q]  <= KIND_DONE;
											phase_q[serving_q] <= SPH_DONE;
										end
									end
									KIND_DONE: begin
										occ_q[serving_q]  <= 1'b0;
										kind_q[serving_q] <= KIND_NONE;
										if (next_found) begin
											serving_q         <= next_idx;
											phase_q[next_idx] <= SPH_START;
										end else begin
											serving_q <= '0;
										end
									end
									default: begin
									end
								endcase
							end
							default: begin
								ip_q <= IP_POWER;
							end
						endcase
					end
					CMD_STRING: begin
						if (!str_go) begin
							status_q <= ST_NO_SLOT;
						end else begin
							if (!open_q) begin
								occ_q[free_idx]   <= 1'b1;
								kind_q[free_idx]  <= KIND_NONE;
								phase_q[free_idx] <= SPH_START;
								open_q            <= 1'b1;
								open_slot_q       <= free_idx;
							end
							if (!str_room) begin
								status_q <= ST_TOO_LONG;
							end
							if (item_s1.last_char) begin
								kind_q[str_slot]  <= KIND_WRITE;
								phase_q[str_slot] <= SPH_START;
								open_q            <= 1'b0;
							end else begin
								open_len_q <= str_len_n;
							end
						end
					end
					CMD_CLEAR, CMD_RAW, CMD_POSITION: begin
						if (!is_enq) begin
							status_q <= ST_BAD_POS;
						end else if (!free_found) begin
							status_q <= ST_NO_SLOT;
						end else begin
							occ_q[free_idx]   <= 1'b1;
							kind_q[free_idx]  <= enq_kind;
							phase_q[free_idx] <= SPH_START;
						end
					end
					default: begin
					end
				endcase
			end
		end
	end

	assign rsp.status      = status_q;
	assign rsp.lcd_rs      = rs_q;
	assign rsp.lcd_enable  = en_q;
	assign rsp.lcd_data    = data_q;
	assign rsp.operational = (ip_q == IP_RUN);

endmodule
